[hw/rtl/cxy_pkg.sv]
package cxy_pkg;

  // Default number of fraction bits of the chromaticity outputs
  localparam int COORD_BITS_DEF = 16;

  // Linear-light channel, Q1.30, at most exactly one
  localparam int LIN_FRAC = 30;
  localparam int LIN_W    = LIN_FRAC + 1;

  // Matrix coefficients in millionths, all below 2^20
  localparam int COEF_W = 20;

  // One coefficient times one channel, and the sum of three of them
  localparam int PROD_W = LIN_W + COEF_W;
  localparam int SUM_W  = PROD_W + 1;

  localparam int ROM_DEPTH = 256;

  typedef logic [LIN_W-1:0]  lin_t;
  typedef logic [COEF_W-1:0] coef_t;
  typedef logic [PROD_W-1:0] prod_t;
  typedef logic [SUM_W-1:0]  sum_t;

  typedef lin_t lin_rom_t [ROM_DEPTH];

  // Rows give X, Y, Z; columns give R, G, B
  localparam coef_t MatCoef [3][3] = '{
    '{20'd664511, 20'd154324, 20'd162028},
    '{20'd283881, 20'd668433, 20'd47685},
    '{20'd88,     20'd72310,  20'd986039}
  };

  // sRGB decode of one byte to Q1.30; evaluated at elaboration only
  function automatic logic [63:0] lin_value(input logic [7:0] c);
    logic [63:0] cc;
    logic [63:0] one;
    logic [63:0] t;
    logic [63:0] q;
    logic [63:0] r;
    logic [63:0] cand;
    logic [63:0] p;
    cc  = 64'(c);
    one = 64'd1 << LIN_FRAC;
    if (cc * 64'd100000 <= 64'd1031475) begin
      return (cc * 64'd100 * one) / 64'd329460;
    end
    t = ((cc * 64'd1000 + 64'd14025) * one) / 64'd269025;
    q = (t * t) >> LIN_FRAC;
    r = '0;
    // fifth root of q, one bit at a time from the top
    for (int idx = LIN_FRAC; idx >= 0; idx--) begin
      cand = r | (64'd1 << idx);
      p    = cand;
      for (int k = 0; k < 4; k++) begin
        p = (p * cand) >> LIN_FRAC;
      end
      if (cand <= one && p <= q) begin
        r = cand;
      end
    end
    return (q * r) >> LIN_FRAC;
  endfunction

  function automatic lin_rom_t build_lin_rom();
    lin_rom_t rom;
    logic [63:0] v;
    for (int i = 0; i < ROM_DEPTH; i++) begin
      v      = lin_value(8'(i));
      rom[i] = v[LIN_W-1:0];
    end
    return rom;
  endfunction

  // Gamma decode table, indexed by the channel byte
  localparam lin_rom_t LinRom = build_lin_rom();

endpackage

[hw/rtl/cxy_linearize.sv]
module cxy_linearize (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      red,
  input  logic [7:0]      green,
  input  logic [7:0]      blue,
  output logic            out_valid,
  input  logic            out_ready,
  output cxy_pkg::lin_t   lin_r_r,
  output cxy_pkg::lin_t   lin_g_r,
  output cxy_pkg::lin_t   lin_b_r,
  output logic            black_r
);

  logic vld_r;

  // stage takes a new transfer when empty or when its content moves on
  assign in_ready  = !vld_r || out_ready;
  assign out_valid = vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  // table lookups; an all-zero triple is the only one with zero luminance sum
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      lin_r_r <= cxy_pkg::LinRom[red];
      lin_g_r <= cxy_pkg::LinRom[green];
      lin_b_r <= cxy_pkg::LinRom[blue];
      black_r <= (red == 8'd0) && (green == 8'd0) && (blue == 8'd0);
    end
  end

endmodule

[hw/rtl/cxy_matrix.sv]
module cxy_matrix (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  cxy_pkg::lin_t   lin_r,
  input  cxy_pkg::lin_t   lin_g,
  input  cxy_pkg::lin_t   lin_b,
  input  logic            black,
  output logic            out_valid,
  input  logic            out_ready,
  output cxy_pkg::sum_t   x_r,
  output cxy_pkg::sum_t   y_r,
  output cxy_pkg::sum_t   s_r,
  output logic            black_r
);

  cxy_pkg::lin_t  lin_in [3];
  cxy_pkg::prod_t prod_r [3][3];
  cxy_pkg::sum_t  xyz_r  [3];
  logic           blk1_r;
  logic           blk2_r;
  logic           v1_r;
  logic           v2_r;
  logic           v3_r;
  logic           rdy1;
  logic           rdy2;
  logic           rdy3;

  assign lin_in[0] = lin_r;
  assign lin_in[1] = lin_g;
  assign lin_in[2] = lin_b;

  // per-stage hold chain, bubbles are squeezed out
  assign rdy3      = !v3_r || out_ready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign out_valid = v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  // stage 1: nine constant products
  for (genvar gr = 0; gr < 3; gr++) begin : g_row
    for (genvar gc = 0; gc < 3; gc++) begin : g_col
      always_ff @(posedge clk) begin
        if (rdy1 && in_valid) begin
          prod_r[gr][gc] <= cxy_pkg::PROD_W'(lin_in[gc])
                          * cxy_pkg::PROD_W'(cxy_pkg::MatCoef[gr][gc]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      blk1_r <= black;
    end
  end

  // stage 2: X, Y, Z
  for (genvar gr = 0; gr < 3; gr++) begin : g_sum
    always_ff @(posedge clk) begin
      if (rdy2 && v1_r) begin
        xyz_r[gr] <= cxy_pkg::SUM_W'(prod_r[gr][0]) + cxy_pkg::SUM_W'(prod_r[gr][1])
                   + cxy_pkg::SUM_W'(prod_r[gr][2]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      blk2_r <= blk1_r;
    end
  end

  // stage 3: divisor X+Y+Z, stays below 2^52
  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      x_r     <= xyz_r[0];
      y_r     <= xyz_r[1];
      s_r     <= xyz_r[0] + xyz_r[1] + xyz_r[2];
      black_r <= blk2_r;
    end
  end

endmodule

[hw/rtl/cxy_divider.sv]
module cxy_divider #(
  parameter int COORD_BITS = cxy_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  cxy_pkg::sum_t         x_num,
  input  cxy_pkg::sum_t         y_num,
  input  cxy_pkg::sum_t         den,
  input  logic                  black,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] quo_x,
  output logic [COORD_BITS-1:0] quo_y,
  output logic                  black_out
);

  localparam int RemW = cxy_pkg::SUM_W + 1;

  // one quotient bit of each coordinate per stage
  cxy_pkg::sum_t         rem_x_r [COORD_BITS];
  cxy_pkg::sum_t         rem_y_r [COORD_BITS];
  cxy_pkg::sum_t         den_r   [COORD_BITS];
  logic [COORD_BITS-1:0] quo_x_r [COORD_BITS];
  logic [COORD_BITS-1:0] quo_y_r [COORD_BITS];
  logic                  blk_r   [COORD_BITS];
  logic [COORD_BITS-1:0] vld_r;
  logic [COORD_BITS:0]   rdy;

  assign rdy[COORD_BITS] = out_ready;
  assign in_ready        = rdy[0];

  for (genvar gi = 0; gi < COORD_BITS; gi++) begin : g_stage
    cxy_pkg::sum_t         src_rem_x;
    cxy_pkg::sum_t         src_rem_y;
    cxy_pkg::sum_t         src_den;
    logic [COORD_BITS-1:0] src_quo_x;
    logic [COORD_BITS-1:0] src_quo_y;
    logic                  src_blk;
    logic                  src_vld;
    logic [RemW-1:0]       sh_x;
    logic [RemW-1:0]       sh_y;
    logic [RemW-1:0]       dif_x;
    logic [RemW-1:0]       dif_y;
    logic                  ge_x;
    logic                  ge_y;

    if (gi == 0) begin : g_first
      assign src_rem_x = x_num;
      assign src_rem_y = y_num;
      assign src_den   = den;
      assign src_quo_x = '0;
      assign src_quo_y = '0;
      assign src_blk   = black;
      assign src_vld   = in_valid;
    end else begin : g_next
      assign src_rem_x = rem_x_r[gi-1];
      assign src_rem_y = rem_y_r[gi-1];
      assign src_den   = den_r[gi-1];
      assign src_quo_x = quo_x_r[gi-1];
      assign src_quo_y = quo_y_r[gi-1];
      assign src_blk   = blk_r[gi-1];
      assign src_vld   = vld_r[gi-1];
    end

    assign rdy[gi] = !vld_r[gi] || rdy[gi+1];

    // restoring step: remainder stays below the divisor
    assign sh_x  = {src_rem_x, 1'b0};
    assign sh_y  = {src_rem_y, 1'b0};
    assign dif_x = sh_x - {1'b0, src_den};
    assign dif_y = sh_y - {1'b0, src_den};
    assign ge_x  = sh_x >= {1'b0, src_den};
    assign ge_y  = sh_y >= {1'b0, src_den};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[gi] <= 1'b0;
      end else if (rdy[gi]) begin
        vld_r[gi] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[gi] && src_vld) begin
        rem_x_r[gi] <= ge_x ? dif_x[cxy_pkg::SUM_W-1:0] : sh_x[cxy_pkg::SUM_W-1:0];
        rem_y_r[gi] <= ge_y ? dif_y[cxy_pkg::SUM_W-1:0] : sh_y[cxy_pkg::SUM_W-1:0];
        quo_x_r[gi] <= {src_quo_x[COORD_BITS-2:0], ge_x};
        quo_y_r[gi] <= {src_quo_y[COORD_BITS-2:0], ge_y};
        den_r[gi]   <= src_den;
        blk_r[gi]   <= src_blk;
      end
    end
  end

  // a zero divisor yields all ones in the array; black forces zero
  assign out_valid = vld_r[COORD_BITS-1];
  assign black_out = blk_r[COORD_BITS-1];
  assign quo_x     = blk_r[COORD_BITS-1] ? '0 : quo_x_r[COORD_BITS-1];
  assign quo_y     = blk_r[COORD_BITS-1] ? '0 : quo_y_r[COORD_BITS-1];

endmodule

[hw/rtl/rgb_to_cie_xy_core.sv]
// sRGB byte triple to CIE 1931 xy chromaticity.
//
// Input channel: in_valid / in_stall with in_red_in, in_green_in and
// in_blue_in, one gamma-encoded triple per transfer. Result channel:
// out_valid / out_stall with out_chroma_x, out_chroma_y (unsigned,
// COORD_BITS fraction bits, all ones for a ratio of one) and out_is_black.
// A transfer happens on a rising edge with valid high and stall low.
//
// The path runs through a gamma table lookup stage, the matrix product,
// sum and divisor stages, then one divider stage per quotient bit. One
// triple can be taken every cycle while out_stall is low; the slowest
// stage is one 53-bit compare-subtract of the divider.
//
// Every stage holds its own item and valid bit. When out_stall is high the
// last stage holds its result steady and earlier stages keep filling any
// empty slot, so in_stall rises only once the whole pipeline is full.
// An all-black triple gives x = y = 0 with out_is_black set.
// Synchronous reset empties the pipeline; results in flight are dropped.
module rgb_to_cie_xy_core #(
  parameter int COORD_BITS = cxy_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            in_red_in,
  input  logic [7:0]            in_green_in,
  input  logic [7:0]            in_blue_in,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [COORD_BITS-1:0] out_chroma_x,
  output logic [COORD_BITS-1:0] out_chroma_y,
  output logic                  out_is_black
);

  logic          lin_in_ready;
  logic          lin_valid;
  logic          mat_in_ready;
  logic          mat_valid;
  logic          div_in_ready;
  cxy_pkg::lin_t lin_r;
  cxy_pkg::lin_t lin_g;
  cxy_pkg::lin_t lin_b;
  logic          lin_black;
  cxy_pkg::sum_t mat_x;
  cxy_pkg::sum_t mat_y;
  cxy_pkg::sum_t mat_s;
  logic          mat_black;

  assign in_stall = !lin_in_ready;

  // gamma decode
  cxy_linearize u_lin (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (lin_in_ready),
    .red       (in_red_in),
    .green     (in_green_in),
    .blue      (in_blue_in),
    .out_valid (lin_valid),
    .out_ready (mat_in_ready),
    .lin_r_r   (lin_r),
    .lin_g_r   (lin_g),
    .lin_b_r   (lin_b),
    .black_r   (lin_black)
  );

  // RGB to XYZ and divisor
  cxy_matrix u_mat (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (lin_valid),
    .in_ready  (mat_in_ready),
    .lin_r     (lin_r),
    .lin_g     (lin_g),
    .lin_b     (lin_b),
    .black     (lin_black),
    .out_valid (mat_valid),
    .out_ready (div_in_ready),
    .x_r       (mat_x),
    .y_r       (mat_y),
    .s_r       (mat_s),
    .black_r   (mat_black)
  );

  // x = X/S and y = Y/S
  cxy_divider #(
    .COORD_BITS (COORD_BITS)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (mat_valid),
    .in_ready  (div_in_ready),
    .x_num     (mat_x),
    .y_num     (mat_y),
    .den       (mat_s),
    .black     (mat_black),
    .out_valid (out_valid),
    .out_ready (!out_stall),
    .quo_x     (out_chroma_x),
    .quo_y     (out_chroma_y),
    .black_out (out_is_black)
  );

endmodule

[hw/rtl/cxy_checker.sv]
module cxy_checker #(
  parameter int COORD_BITS = cxy_pkg::COORD_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic [7:0]            in_red_in,
  input logic [7:0]            in_green_in,
  input logic [7:0]            in_blue_in,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [COORD_BITS-1:0] out_chroma_x,
  input logic [COORD_BITS-1:0] out_chroma_y,
  input logic                  out_is_black
);

  // a held result does not change
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_chroma_x)
      && $stable(out_chroma_y) && $stable(out_is_black))
    else $error("result changed while stalled");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  // input backpressure only when a result is held at the output
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with room in the pipeline");

  // black flag forces both coordinates to zero
  a_black_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_black |-> out_chroma_x == '0 && out_chroma_y == '0)
    else $error("black result with nonzero chromaticity");

endmodule

bind rgb_to_cie_xy_core cxy_checker #(.COORD_BITS(COORD_BITS)) u_cxy_checker (.*);
